@@ rtl/per_token_4bit_value_quantizer_core_defines.svh @@
// Assertion helpers shared by the quantizer RTL.
`ifndef PER_TOKEN_4BIT_VALUE_QUANTIZER_CORE_DEFINES_SVH
`define PER_TOKEN_4BIT_VALUE_QUANTIZER_CORE_DEFINES_SVH

// A condition that must hold in every cycle out of reset.
`define PTQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define PTQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/ptq_pkg.sv @@
`timescale 1ns / 1ps
package ptq_pkg;

    // Single precision constants.
    localparam logic [31:0] FP_SEVEN   = 32'h40E0_0000;
    localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_ALL1   = 8'hFF;

    // Output codes.
    localparam logic [3:0] CODE_ZERO = 4'd0;
    localparam logic [3:0] CODE_MIN  = 4'd1;
    localparam logic [3:0] CODE_MID  = 4'd8;
    localparam logic [3:0] CODE_MAX  = 4'd15;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } ptq_div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] q;
    } ptq_div_rsp_t;

    // Turns a quotient into a nibble: round half away from zero, clamp to -7..7, add 8.
    function automatic logic [3:0] quant_code(input logic [31:0] q);
        logic [7:0]  e;
        logic [23:0] sig;
        logic [23:0] twice;
        logic [4:0]  sh;
        logic [3:0]  n;
        e     = q[30:23];
        sig   = {1'b1, q[22:0]};
        n     = 4'd0;
        twice = 24'd0;
        sh    = 5'd0;
        if (e == EXP_ALL1 && q[22:0] != 23'd0) begin
            return CODE_MID;
        end
        if (e > 8'd129 || (e == 8'd129 && q[22:0] >= 23'h60_0000)) begin
            return q[31] ? CODE_MIN : CODE_MAX;
        end
        if (e >= 8'd126) begin
            sh    = 5'(8'd149 - e);
            twice = sig >> sh;
            n     = 4'((twice + 24'd1) >> 1);
        end
        return q[31] ? (CODE_MID - n) : (CODE_MID + n);
    endfunction

endpackage

@@ rtl/ptq_ram.sv @@
`timescale 1ns / 1ps
module ptq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port with registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ptq_fdiv.sv @@
`timescale 1ns / 1ps
module ptq_fdiv
    import ptq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ptq_div_req_t req,
    output ptq_div_rsp_t rsp
);

    typedef enum logic [5:0] {
        D_IDLE  = 6'b000001,
        D_NORM  = 6'b000010,
        D_DIV   = 6'b000100,
        D_ALIGN = 6'b001000,
        D_SHIFT = 6'b010000,
        D_ROUND = 6'b100000
    } dstate_t;

    dstate_t            state_reg;
    logic               done_reg;
    logic [31:0]        q_reg;
    logic               sign_reg;
    logic [23:0]        ma_reg, mb_reg;
    logic signed [10:0] ea_reg, eb_reg, e_reg;
    logic [24:0]        rem_reg;
    logic [25:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic [24:0]        x_reg;
    logic               st_reg;
    logic               sub_reg;

    // Operand classification.
    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, q_sign;
    assign a_nan  = req.a[30:23] == EXP_ALL1 && req.a[22:0] != 23'd0;
    assign a_inf  = req.a[30:23] == EXP_ALL1 && req.a[22:0] == 23'd0;
    assign a_zero = req.a[30:0] == 31'd0;
    assign b_nan  = req.b[30:23] == EXP_ALL1 && req.b[22:0] != 23'd0;
    assign b_inf  = req.b[30:23] == EXP_ALL1 && req.b[22:0] == 23'd0;
    assign b_zero = req.b[30:0] == 31'd0;
    assign q_sign = req.a[31] ^ req.b[31];

    // Restoring division step.
    logic        ge;
    logic [24:0] diff;
    assign ge   = rem_reg >= {1'b0, mb_reg};
    assign diff = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

    // Alignment of the raw quotient.
    logic signed [10:0] e_align;
    assign e_align = ea_reg - eb_reg + 11'sd127 - (quo_reg[25] ? 11'sd0 : 11'sd1);

    // Rounding to nearest even.
    logic               inc;
    logic [24:0]        s25;
    logic signed [10:0] e_fin;
    assign inc   = x_reg[0] & (st_reg | x_reg[1]);
    assign s25   = {1'b0, x_reg[24:1]} + {24'd0, inc};
    assign e_fin = e_reg + {10'd0, s25[24]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        sign_reg <= q_sign;
                        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                            q_reg    <= FP_QNAN;
                            done_reg <= 1'b1;
                        end else if (a_inf || b_zero) begin
                            q_reg    <= {q_sign, EXP_ALL1, 23'd0};
                            done_reg <= 1'b1;
                        end else if (a_zero || b_inf) begin
                            q_reg    <= {q_sign, 31'd0};
                            done_reg <= 1'b1;
                        end else begin
                            ma_reg    <= {req.a[30:23] != 8'd0, req.a[22:0]};
                            mb_reg    <= {req.b[30:23] != 8'd0, req.b[22:0]};
                            ea_reg    <= (req.a[30:23] == 8'd0) ? 11'sd1 : {3'd0, req.a[30:23]};
                            eb_reg    <= (req.b[30:23] == 8'd0) ? 11'sd1 : {3'd0, req.b[30:23]};
                            state_reg <= D_NORM;
                        end
                    end
                end
                D_NORM: begin
                    // Subnormal operands shift up one bit a cycle.
                    if (ma_reg[23] && mb_reg[23]) begin
                        rem_reg   <= {1'b0, ma_reg};
                        quo_reg   <= 26'd0;
                        cnt_reg   <= 5'd0;
                        state_reg <= D_DIV;
                    end else begin
                        if (!ma_reg[23]) begin
                            ma_reg <= {ma_reg[22:0], 1'b0};
                            ea_reg <= ea_reg - 11'sd1;
                        end
                        if (!mb_reg[23]) begin
                            mb_reg <= {mb_reg[22:0], 1'b0};
                            eb_reg <= eb_reg - 11'sd1;
                        end
                    end
                end
                D_DIV: begin
                    rem_reg <= {diff[23:0], 1'b0};
                    quo_reg <= {quo_reg[24:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd25) begin
                        state_reg <= D_ALIGN;
                    end
                end
                D_ALIGN: begin
                    if (quo_reg[25]) begin
                        x_reg  <= quo_reg[25:1];
                        st_reg <= quo_reg[0] | (rem_reg != 25'd0);
                    end else begin
                        x_reg  <= quo_reg[24:0];
                        st_reg <= rem_reg != 25'd0;
                    end
                    sub_reg <= e_align <= 11'sd0;
                    e_reg   <= (e_align < -11'sd25) ? -11'sd25 : e_align;
                    state_reg <= (e_align <= 11'sd0) ? D_SHIFT : D_ROUND;
                end
                D_SHIFT: begin
                    // Subnormal result: shift down into the sticky bit.
                    st_reg <= st_reg | x_reg[0];
                    x_reg  <= {1'b0, x_reg[24:1]};
                    e_reg  <= e_reg + 11'sd1;
                    if (e_reg == 11'sd0) begin
                        state_reg <= D_ROUND;
                    end
                end
                D_ROUND: begin
                    if (sub_reg) begin
                        q_reg <= {sign_reg, 7'd0, s25[23], s25[22:0]};
                    end else if (e_fin >= 11'sd255) begin
                        q_reg <= {sign_reg, EXP_ALL1, 23'd0};
                    end else begin
                        q_reg <= {sign_reg, e_fin[7:0], s25[22:0]};
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = state_reg != D_IDLE;
    assign rsp.q    = q_reg;

endmodule

@@ rtl/per_token_4bit_value_quantizer_core.sv @@
`timescale 1ns / 1ps
// Per-token 4-bit quantizer: fp32 values enter one per request and fill a row of
// row_length entries (0 acts as 1, above MAX_ROW as MAX_ROW) while the peak |value|
// is tracked; input takes one value per cycle. When a row completes, input stalls
// and one shared iterative fp32 divider first forms scale = peak / 7, then divides
// each stored value by the scale. The divider normalizes a subnormal operand one
// leading zero at a time and shifts a subnormal result down one bit at a time; each
// value is read from the row memory, divided and offered as an output request before
// the next is read. A zero scale skips the divider and gives code 0 for every value.
module per_token_4bit_value_quantizer_core
    import ptq_pkg::*;
#(
    parameter int MAX_ROW = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_code_nibble,
    output logic [31:0] m_row_scale_bits,
    output logic        m_last_in_row
);

`include "per_token_4bit_value_quantizer_core_defines.svh"

    localparam int AW = $clog2(MAX_ROW > 1 ? MAX_ROW : 2);
    localparam int CW = $clog2(MAX_ROW + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_SWAIT = 7'b0000100,
        S_READ  = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t         state_reg;
    logic [6:0]     row_length_reg;
    logic [CW-1:0]  fill_reg;
    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  idx_reg;
    logic [31:0]    peak_reg;
    logic [31:0]    scale_reg;
    logic [3:0]     code_reg;
    logic           last_reg;

    ptq_div_req_t   div_req;
    ptq_div_rsp_t   div_rsp;
    logic [31:0]    ram_rdata;

    // Effective row length.
    logic [CW-1:0] eff_len;
    always_comb begin
        if (row_length_reg == 7'd0) begin
            eff_len = CW'(1);
        end else if (row_length_reg > 7'(MAX_ROW)) begin
            eff_len = CW'(MAX_ROW);
        end else begin
            eff_len = row_length_reg[CW-1:0];
        end
    end

    // Input request bookkeeping.
    logic          s_fire;
    logic [CW-1:0] new_count;
    logic [31:0]   abs_in;
    logic          abs_nan;
    assign s_ready   = state_reg == S_IDLE;
    assign s_fire    = s_valid && s_ready;
    assign new_count = fill_reg + CW'(1);
    assign abs_in    = {1'b0, s_value_bits[30:0]};
    assign abs_nan   = s_value_bits[30:23] == EXP_ALL1 && s_value_bits[22:0] != 23'd0;

    logic scale_zero;
    logic idx_last;
    assign scale_zero = scale_reg[30:0] == 31'd0;
    assign idx_last   = (CW'(idx_reg) + CW'(1)) == count_reg;

    // Row memory.
    ptq_ram #(.WIDTH(32), .DEPTH(MAX_ROW)) u_row_ram (
        .aclk  (aclk),
        .we    (s_fire),
        .addr  (s_ready ? fill_reg[AW-1:0] : idx_reg),
        .wdata (s_value_bits),
        .rdata (ram_rdata)
    );

    // Divider operands.
    always_comb begin
        div_req.start = (state_reg == S_SCALE) || (state_reg == S_LOAD && !scale_zero);
        div_req.a     = (state_reg == S_SCALE) ? peak_reg : ram_rdata;
        div_req.b     = (state_reg == S_SCALE) ? FP_SEVEN : scale_reg;
    end

    ptq_fdiv u_fdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= 7'd64;
        end else if (cfg_we) begin
            row_length_reg <= cfg_wdata;
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            peak_reg  <= 32'd0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (!abs_nan && abs_in > peak_reg) begin
                            peak_reg <= abs_in;
                        end
                        fill_reg <= new_count;
                        if (new_count >= eff_len) begin
                            count_reg <= new_count;
                            state_reg <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    state_reg <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (div_rsp.done) begin
                        scale_reg <= div_rsp.q;
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    last_reg <= idx_last;
                    if (scale_zero) begin
                        code_reg  <= CODE_ZERO;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        code_reg  <= quant_code(div_rsp.q);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (last_reg) begin
                            fill_reg  <= '0;
                            peak_reg  <= 32'd0;
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = state_reg == S_OUT;
    assign m_code_nibble    = code_reg;
    assign m_row_scale_bits = scale_reg;
    assign m_last_in_row    = last_reg;

    `PTQ_ASSERT(a_no_overlap, !(m_valid && s_ready), "input taken while a result is pending")
    `PTQ_ASSERT(a_fill_bound, !s_ready || fill_reg < CW'(MAX_ROW),
        "fill count reached the row limit")
    `PTQ_ASSERT(a_last_index, !m_valid || (m_last_in_row == idx_last), "last flag off its index")
    `PTQ_ASSERT_NEXT(a_row_clear, m_valid && m_ready && m_last_in_row, fill_reg == '0 && s_ready,
        "row not cleared after its last result")
    `PTQ_ASSERT(a_div_idle_start, !div_req.start || !div_rsp.busy, "divider started while busy")

endmodule

@@ tb/sv/per_token_4bit_value_quantizer_core_test.sv @@
`timescale 1ns / 1ps
module per_token_4bit_value_quantizer_core_test;
    import ptq_pkg::*;

    localparam int MAX_ROW    = 64;
    localparam int STALL_STOP = 20000;

    // One quantized element as it leaves the block.
    typedef struct packed {
        logic [3:0]  code;
        logic [31:0] scale;
        logic        last;
    } code_item_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_value_bits;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_code_nibble;
    logic [31:0] m_row_scale_bits;
    logic        m_last_in_row;

    per_token_4bit_value_quantizer_core #(.MAX_ROW(MAX_ROW)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value_bits     (s_value_bits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_nibble    (m_code_nibble),
        .m_row_scale_bits (m_row_scale_bits),
        .m_last_in_row    (m_last_in_row)
    );

    // Model state of the quantizer.
    logic [31:0] row_values [MAX_ROW];
    int          row_fill;
    logic [31:0] row_peak;
    logic [6:0]  row_len_reg;

    code_item_t  pending_codes [$];
    int          err_count;
    int          values_sent;
    int          codes_checked;
    int          rows_done;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          recv_hold_left;
    int          quiet_cycles;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Single precision division, round to nearest even, with subnormals.
    function automatic logic [31:0] fp32_divide(input logic [31:0] x, input logic [31:0] y);
        logic        sgn;
        logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
        logic [63:0] mx, my, quo, kept, packed_bits;
        int          ex, ey, e, p, shift;
        logic        guard, sticky;
        sgn    = x[31] ^ y[31];
        x_nan  = x[30:23] == 8'hFF && x[22:0] != 0;
        y_nan  = y[30:23] == 8'hFF && y[22:0] != 0;
        x_inf  = x[30:0] == 31'h7F80_0000;
        y_inf  = y[30:0] == 31'h7F80_0000;
        x_zero = x[30:0] == 0;
        y_zero = y[30:0] == 0;
        if (x_nan || y_nan || (x_inf && y_inf) || (x_zero && y_zero)) begin
            return FP_QNAN;
        end
        if (x_inf || y_zero) begin
            return {sgn, 31'h7F80_0000};
        end
        if (x_zero || y_inf) begin
            return {sgn, 31'h0};
        end
        // Unpack as integer significand times a power of two, then normalize.
        mx = (x[30:23] == 0) ? {41'd0, x[22:0]} : {40'd0, 1'b1, x[22:0]};
        ex = (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
        my = (y[30:23] == 0) ? {41'd0, y[22:0]} : {40'd0, 1'b1, y[22:0]};
        ey = (y[30:23] == 0) ? -149 : int'(y[30:23]) - 150;
        while (!mx[23]) begin
            mx = mx << 1;
            ex = ex - 1;
        end
        while (!my[23]) begin
            my = my << 1;
            ey = ey - 1;
        end
        quo    = (mx << 26) / my;
        sticky = ((mx << 26) % my) != 0;
        e      = ex - ey - 26;
        p      = 0;
        for (int i = 0; i < 64; i++) begin
            if (quo[i]) p = i;
        end
        shift = (p + e >= -126) ? p - 23 : -149 - e;
        if (shift > 40) begin
            kept   = 0;
            guard  = 1'b0;
            sticky = 1'b1;
        end else begin
            kept   = quo >> shift;
            guard  = quo[shift-1];
            sticky = sticky | ((quo & ((64'd1 << (shift - 1)) - 1)) != 0);
        end
        // The hidden bit of a normal result carries into the exponent field.
        if (p + e >= -126) begin
            packed_bits = (64'(p + e + 126) << 23) + kept;
        end else begin
            packed_bits = kept;
        end
        if (guard && (sticky || kept[0])) packed_bits = packed_bits + 1;
        if (packed_bits >= 64'h7F80_0000) packed_bits = 64'h7F80_0000;
        return {sgn, packed_bits[30:0]};
    endfunction

    // Nibble for one value against a nonzero scale.
    function automatic logic [3:0] nibble_for(input logic [31:0] v, input logic [31:0] scale);
        logic [31:0] q;
        logic [23:0] twice;
        logic [3:0]  n;
        q = fp32_divide(v, scale);
        n = 4'd0;
        if (q[30:23] == 8'hFF && q[22:0] != 0) return CODE_MID;
        if (q[30:0] >= 31'h40E0_0000) return q[31] ? CODE_MIN : CODE_MAX;
        // Below 7 the value is exact, so twice the magnitude decides the rounding.
        if (q[30:23] >= 8'd126) begin
            twice = {1'b1, q[22:0]} >> (149 - int'(q[30:23]));
            n     = 4'((twice + 24'd1) >> 1);
        end
        return q[31] ? CODE_MID - n : CODE_MID + n;
    endfunction

    // Buffers one accepted value and queues the row's codes when it completes.
    task automatic quantize_predict(input logic [31:0] v);
        int          eff_len;
        logic [31:0] scale;
        code_item_t  item;
        eff_len = (row_len_reg == 0) ? 1 : (row_len_reg > MAX_ROW) ? MAX_ROW : int'(row_len_reg);
        row_values[row_fill] = v;
        row_fill++;
        if (v[30:0] <= 31'h7F80_0000 && v[30:0] > row_peak[30:0]) row_peak = {1'b0, v[30:0]};
        if (row_fill >= eff_len) begin
            scale = fp32_divide(row_peak, FP_SEVEN);
            for (int i = 0; i < row_fill; i++) begin
                item.code  = (scale == 0) ? CODE_ZERO : nibble_for(row_values[i], scale);
                item.scale = scale;
                item.last  = (i == row_fill - 1);
                pending_codes.push_back(item);
            end
            row_fill = 0;
            row_peak = 0;
            rows_done++;
        end
    endtask

    // Offers one value, waits for its request to be taken, then predicts it.
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_value_bits = v;
        do @(posedge aclk); while (!s_ready);
        quantize_predict(v);
        values_sent++;
        @(negedge aclk);
    endtask

    // Waits until every queued code has come out and the block has settled.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_row_length(input logic [6:0] len);
        cfg_we    = 1'b1;
        cfg_wdata = len;
        @(negedge aclk);
        cfg_we      = 1'b0;
        row_len_reg = len;
    endtask

    // Mostly moderate values; some raw patterns, zeros, subnormals and rare specials.
    function automatic logic [31:0] random_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return r;
            1: return {r[31], 31'h0};
            2: return {r[31], 8'h00, r[22:0]};
            3: begin
                if ($urandom_range(3) == 0) return {r[31], 8'hFF, r[22:0]};
                return {r[31], 8'(118 + $urandom_range(14)), r[22:0]};
            end
            default: return {r[31], 8'(118 + $urandom_range(14)), r[22:0]};
        endcase
    endfunction

    // Check every code that leaves the block against the oldest prediction.
    always @(posedge aclk) begin
        code_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected code %0d scale %h", m_code_nibble, m_row_scale_bits);
                err_count++;
            end else begin
                want = pending_codes.pop_front();
                codes_checked++;
                if (m_code_nibble !== want.code) begin
                    $error("code_nibble expected %0d actual %0d", want.code, m_code_nibble);
                    err_count++;
                end
                if (m_row_scale_bits !== want.scale) begin
                    $error("row_scale_bits expected %h actual %h", want.scale,
                           m_row_scale_bits);
                    err_count++;
                end
                if (m_last_in_row !== want.last) begin
                    $error("last_in_row expected %0b actual %0b", want.last, m_last_in_row);
                    err_count++;
                end
            end
        end
    end

    // Receiver: a long hold when asked, otherwise random stalls.
    always @(negedge aclk) begin
        if (recv_hold_left > 0) begin
            m_ready        <= 1'b0;
            recv_hold_left <= recv_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stop a hung run when no request moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_STOP) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The reset length of 64 is used before any write.
    task automatic test_default_length();
        for (int i = 0; i < MAX_ROW; i++) send_value(random_value());
        wait_drained();
    endtask

    // Field extremes, zero rows, specials, exact ties and a length cut mid-row.
    task automatic test_directed();
        write_row_length(7'd0);
        send_value(32'h0000_0000);
        send_value(32'h8000_0000);
        wait_drained();
        write_row_length(7'd4);
        send_value(32'h7F7F_FFFF);
        send_value(32'hFF7F_FFFF);
        send_value(32'h3F80_0000);
        send_value(32'hBF80_0000);
        wait_drained();
        // Peak so small that the scale underflows to zero.
        write_row_length(7'd2);
        send_value(32'h0000_0001);
        send_value(32'h8000_0001);
        wait_drained();
        // Infinite and NaN members of one row.
        write_row_length(7'd4);
        send_value(32'h7F80_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h3F80_0000);
        send_value(32'h8000_0000);
        wait_drained();
        // Peak of 7 gives a scale of 1, so halves land on exact ties.
        write_row_length(7'd5);
        send_value(32'h40E0_0000);
        send_value(32'h3F00_0000);
        send_value(32'h4020_0000);
        send_value(32'hC060_0000);
        send_value(32'h40D0_0000);
        wait_drained();
        // Lower the length under the fill count; the next value ends the row.
        write_row_length(7'd8);
        for (int i = 0; i < 5; i++) send_value(random_value());
        wait_drained();
        write_row_length(7'd3);
        send_value(32'h4000_0000);
        wait_drained();
    endtask

    // Rows of random length and content under one idling pattern.
    task automatic test_random_rows(input int idle_pct, input int stall_pct, input int count);
        int          stop_at;
        int          len;
        logic [6:0]  reg_val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = values_sent + count;
        while (values_sent < stop_at) begin
            case ($urandom_range(19))
                0: begin
                    reg_val = ($urandom_range(2) == 0) ? 7'd64 : 7'(65 + $urandom_range(62));
                    len     = MAX_ROW;
                end
                1: begin
                    reg_val = 7'd0;
                    len     = 1;
                end
                default: begin
                    len     = $urandom_range(1, 8);
                    reg_val = 7'(len);
                end
            endcase
            write_row_length(reg_val);
            for (int i = 0; i < len; i++) send_value(random_value());
            wait_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // The receiver holds off while short rows keep coming, so input backs up.
    task automatic test_backpressure();
        write_row_length(7'd2);
        recv_hold_left = 3000;
        for (int i = 0; i < 20; i++) send_value(random_value());
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 7'd0;
        s_valid        = 1'b0;
        s_value_bits   = 32'd0;
        m_ready        = 1'b0;
        row_fill       = 0;
        row_peak       = 0;
        row_len_reg    = 7'd64;
        err_count      = 0;
        values_sent    = 0;
        codes_checked  = 0;
        rows_done      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = 0;
        quiet_cycles   = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_default_length();
        test_directed();
        test_random_rows(0, 0, 35);
        test_random_rows(82, 0, 35);
        test_random_rows(0, 82, 35);
        test_random_rows(19, 19, 35);
        test_backpressure();
        write_row_length(7'd127);
        wait_drained();

        if (pending_codes.size() != 0) begin
            $error("%0d codes never arrived", pending_codes.size());
            err_count++;
        end
        $display("Covered %0d values in %0d rows, %0d codes checked, under four idle patterns",
                 values_sent, rows_done, codes_checked);
        $display("and a long receiver hold; row lengths ran from 0 to 127.");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
